// ----- design/escape_time_fractal_pixel_assert.svh -----
// Assertion macros for the escape-time pixel engine.
// The enclosing module must provide clk and rst_n.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`ifndef SYNTH
`define ETFP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escape_time_fractal_pixel: check failed");
`define ETFP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escape_time_fractal_pixel: check failed");
`else
`define ETFP_ASSERT_IMP(name, ante, cons)
`define ETFP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- design/etfp_pkg.sv -----
package etfp_pkg;

  localparam int FRAC_BITS = 26;
  localparam int ZW = FRAC_BITS + 6;
  localparam int SUM_W = ZW + 8;
  localparam int PROD_W = 2 * ZW;
  localparam int MAX_ROUNDS_DEF = 128;
  localparam int TAB_LEN = 128;
  localparam int IDX_W = 7;
  localparam int COLOR_W = 16;
  localparam int COORD_W = 12;
  localparam int DIM_W = 13;
  localparam int STEP_W = 31;
  localparam int CTR_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam int TAB_RED = 0;
  localparam int TAB_GREEN = 1;
  localparam int TAB_BLUE = 2;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;
  localparam longint PI_Q32 = 64'sd13493037705;
  localparam longint HALF_PI_Q32 = 64'sd6746518852;
  localparam longint ZERO_FOUR_Q32 = 64'sd1717986918;

  // Scaled reciprocals 2^32 / (n * (n - 1)) for n = 13, 11, 9, 7, 5, 3.
  localparam int TAYLOR_TERMS = 6;
  localparam longint unsigned TAYLOR_RECIP [TAYLOR_TERMS] = '{
    (64'd1 << 32) / 64'd156, (64'd1 << 32) / 64'd110, (64'd1 << 32) / 64'd72,
    (64'd1 << 32) / 64'd42, (64'd1 << 32) / 64'd20, (64'd1 << 32) / 64'd6
  };

  typedef logic signed [COLOR_W-1:0] color_tab_t [TAB_LEN];

  // Floor of v / d for v below 2^32: the reciprocal estimate is at most one low.
  function automatic longint unsigned div_small(longint unsigned v, longint unsigned d,
                                                longint unsigned recip);
    longint unsigned q;
    q = (v * recip) >> 32;
    if ((q + 64'd1) * d <= v) q = q + 64'd1;
    return q;
  endfunction

  // Odd Taylor series of sine on a nonnegative Q32 angle, result in Q30.
  function automatic longint sine_q30(longint ang);
    longint r;
    longint x;
    longint t;
    longint res;
    longint unsigned ax;
    longint unsigned x2;
    longint unsigned tu;
    longint unsigned q;
    longint unsigned d;
    int j;
    r = ang;
    while (r >= TWO_PI_Q32) r = r - TWO_PI_Q32;
    if (r > PI_Q32) r = r - TWO_PI_Q32;
    if (r > HALF_PI_Q32) r = PI_Q32 - r;
    else if (r < -HALF_PI_Q32) r = -PI_Q32 - r;
    x = r >>> 2;
    ax = (x < 0) ? -x : x;
    x2 = (ax * ax) >> 30;
    t = Q30_ONE;
    for (j = 0; j < TAYLOR_TERMS; j++) begin
      d = longint'(13 - 2 * j) * longint'(12 - 2 * j);
      tu = t;
      q = div_small((x2 * tu) >> 30, d, TAYLOR_RECIP[j]);
      t = Q30_ONE - signed'(q);
    end
    tu = t;
    res = signed'((ax * tu) >> 30);
    return (x < 0) ? -res : res;
  endfunction

  function automatic color_tab_t build_tab(int sel);
    color_tab_t tab;
    longint ang;
    longint v;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (sel == TAB_RED) ang = longint'(i) <<< 31;
      else if (sel == TAB_GREEN) ang = longint'(i + 5) <<< 32;
      else ang = longint'(i) * ZERO_FOUR_Q32 + HALF_PI_Q32;
      v = (sine_q30(ang) + 64'sd429496730 + 64'sd32768) >>> 16;
      tab[i] = v[COLOR_W-1:0];
    end
    return tab;
  endfunction

  // Clamp to the Q6 range of one z component.
  function automatic logic signed [ZW-1:0] sat_z(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((longint'(1) <<< (ZW - 1)) - 1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[ZW-1:0];
    if (v < lo) return lo[ZW-1:0];
    return v[ZW-1:0];
  endfunction

endpackage

// ----- design/etfp_in_if.sv -----
interface etfp_in_if;
  logic valid;
  logic ready;
  logic [etfp_pkg::COORD_W-1:0] column;
  logic [etfp_pkg::COORD_W-1:0] row;
  modport source(output valid, output column, output row, input ready);
  modport sink(input valid, input column, input row, output ready);
endinterface

// ----- design/etfp_out_if.sv -----
interface etfp_out_if;
  logic valid;
  logic ready;
  logic escaped;
  logic [etfp_pkg::IDX_W-1:0] round_index;
  logic signed [etfp_pkg::COLOR_W-1:0] red;
  logic signed [etfp_pkg::COLOR_W-1:0] green;
  logic signed [etfp_pkg::COLOR_W-1:0] blue;
  modport source(output valid, output escaped, output round_index, output red,
                 output green, output blue, input ready);
  modport sink(input valid, input escaped, input round_index, input red,
               input green, input blue, output ready);
endinterface

// ----- design/etfp_cfg_if.sv -----
interface etfp_cfg_if;
  logic valid;
  logic ready;
  logic [etfp_pkg::CFG_IDX_W-1:0] index;
  logic [etfp_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- design/escape_time_fractal_pixel.sv -----
// Escape-time (Mandelbrot) pixel engine.
// in_ch carries one pixel word (column, row); out_ch returns one word per
// pixel: escape flag, escape round and three Q2.14 color channels.
// cfg_ch writes the view registers by index (center x/y, pixel step, image
// width and height); it is always ready and must only be written while no
// pixel is in flight.
// Every round of the iteration has its own hardware: one stage multiplies
// the current z, the next stage adds c, saturates and tests for escape.
// A new pixel is taken every cycle while the output is not stalled. The
// pipeline has three mapping stages, two stages per round plus a final
// square for the last test, a result stage and the output register.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (center 0,
// step 32768, 640 by 480).
`include "escape_time_fractal_pixel_assert.svh"

module escape_time_fractal_pixel #(
  parameter int MAX_ROUNDS = etfp_pkg::MAX_ROUNDS_DEF
) (
  input logic clk,
  input logic rst_n,
  etfp_cfg_if.sink cfg_ch,
  etfp_in_if.sink in_ch,
  etfp_out_if.source out_ch
);

  localparam int ZW = etfp_pkg::ZW;
  localparam int SW = etfp_pkg::SUM_W;
  localparam int PW = etfp_pkg::PROD_W;
  localparam int FB = etfp_pkg::FRAC_BITS;
  localparam int IW = etfp_pkg::IDX_W;
  localparam int CW = etfp_pkg::COLOR_W;
  localparam int NS = MAX_ROUNDS + 1;
  localparam int DW = etfp_pkg::DIM_W + 1;
  localparam int MW = DW + etfp_pkg::STEP_W + 1;
  localparam etfp_pkg::color_tab_t TAB_R = etfp_pkg::build_tab(etfp_pkg::TAB_RED);
  localparam etfp_pkg::color_tab_t TAB_G = etfp_pkg::build_tab(etfp_pkg::TAB_GREEN);
  localparam etfp_pkg::color_tab_t TAB_B = etfp_pkg::build_tab(etfp_pkg::TAB_BLUE);
  localparam logic [ZW-1:0] FOUR = ZW'(4) << FB;
  localparam logic [SW-1:0] SIXTEEN = SW'(16) << FB;
  localparam logic signed [MW:0] MAP_HI = (MW+1)'((longint'(1) <<< (ZW - 1)) - 1);
  localparam logic signed [MW:0] MAP_LO = -MAP_HI - (MW+1)'(1);

  // Configuration registers.
  logic signed [etfp_pkg::CTR_W-1:0] center_x_r, center_y_r;
  logic [etfp_pkg::STEP_W-1:0] pixel_step_r;
  logic [etfp_pkg::DIM_W-1:0] image_width_r, image_height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      pixel_step_r <= etfp_pkg::STEP_W'(32768);
      image_width_r <= etfp_pkg::DIM_W'(640);
      image_height_r <= etfp_pkg::DIM_W'(480);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        etfp_pkg::REG_CENTER_X: center_x_r <= cfg_ch.data;
        etfp_pkg::REG_CENTER_Y: center_y_r <= cfg_ch.data;
        etfp_pkg::REG_PIXEL_STEP: pixel_step_r <= cfg_ch.data[etfp_pkg::STEP_W-1:0];
        etfp_pkg::REG_IMAGE_WIDTH: image_width_r <= cfg_ch.data[etfp_pkg::DIM_W-1:0];
        etfp_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_ch.data[etfp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld_r;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Mapping: offset from the image middle, times step, plus center.
  logic m0_vld_r, m1_vld_r;
  logic signed [DW-1:0] m0_dx_r, m0_dy_r;
  logic signed [MW-1:0] m1_px_r, m1_py_r;
  logic signed [MW:0] map_x_nxt, map_y_nxt;
  logic signed [ZW-1:0] map_x_sat, map_y_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m0_vld_r <= in_ch.valid;
      m1_vld_r <= m0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_dx_r <= $signed({1'b0, in_ch.column, 1'b0}) - $signed({1'b0, image_width_r});
      m0_dy_r <= $signed({1'b0, in_ch.row, 1'b0}) - $signed({1'b0, image_height_r});
      m1_px_r <= m0_dx_r * $signed({1'b0, pixel_step_r});
      m1_py_r <= m0_dy_r * $signed({1'b0, pixel_step_r});
    end
  end

  assign map_x_nxt = (MW+1)'(m1_px_r >>> 1) + (MW+1)'(center_x_r);
  assign map_y_nxt = (MW+1)'(m1_py_r >>> 1) + (MW+1)'(center_y_r);

  // The mapped point can run far past the Q6 range, so clamp at full width.
  assign map_x_sat = (map_x_nxt > MAP_HI) ? MAP_HI[ZW-1:0] :
                     (map_x_nxt < MAP_LO) ? MAP_LO[ZW-1:0] : map_x_nxt[ZW-1:0];
  assign map_y_sat = (map_y_nxt > MAP_HI) ? MAP_HI[ZW-1:0] :
                     (map_y_nxt < MAP_LO) ? MAP_LO[ZW-1:0] : map_y_nxt[ZW-1:0];

  // Round pipeline: zs holds z_k and c, ms holds the products of z_k.
  logic zs_vld_r [NS];
  logic signed [ZW-1:0] zs_x_r [NS];
  logic signed [ZW-1:0] zs_y_r [NS];
  logic signed [ZW-1:0] zs_cx_r [NS];
  logic signed [ZW-1:0] zs_cy_r [NS];
  logic zs_done_r [NS];
  logic [IW-1:0] zs_idx_r [NS];

  logic ms_vld_r [NS];
  logic signed [PW-1:0] ms_pxx_r [NS];
  logic signed [PW-1:0] ms_pyy_r [NS];
  logic signed [PW-1:0] ms_pxy_r [NS];
  logic ms_big_r [NS];
  logic signed [ZW-1:0] ms_cx_r [NS];
  logic signed [ZW-1:0] ms_cy_r [NS];
  logic ms_done_r [NS];
  logic [IW-1:0] ms_idx_r [NS];

  logic fin_vld_r, fin_esc_r;
  logic [IW-1:0] fin_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) zs_vld_r[0] <= 1'b0;
    else if (adv) zs_vld_r[0] <= m1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zs_x_r[0] <= '0;
      zs_y_r[0] <= '0;
      zs_cx_r[0] <= map_x_sat;
      zs_cy_r[0] <= map_y_sat;
      zs_done_r[0] <= 1'b0;
      zs_idx_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_round
    // The test on z_k reports the round that produced it.
    localparam int RI = (k + etfp_pkg::TAB_LEN - 1) % etfp_pkg::TAB_LEN;
    logic signed [SW-1:0] sqx, sqy, xy;
    logic [SW-1:0] mag2;
    logic esc_nxt, done_nxt;
    logic [IW-1:0] idx_nxt;

    always_ff @(posedge clk) begin
      if (!rst_n) ms_vld_r[k] <= 1'b0;
      else if (adv) ms_vld_r[k] <= zs_vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ms_pxx_r[k] <= zs_x_r[k] * zs_x_r[k];
        ms_pyy_r[k] <= zs_y_r[k] * zs_y_r[k];
        ms_pxy_r[k] <= zs_x_r[k] * zs_y_r[k];
        ms_big_r[k] <= (zs_x_r[k] > $signed(FOUR)) || (zs_x_r[k] < -$signed(FOUR)) ||
                       (zs_y_r[k] > $signed(FOUR)) || (zs_y_r[k] < -$signed(FOUR));
        ms_cx_r[k] <= zs_cx_r[k];
        ms_cy_r[k] <= zs_cy_r[k];
        ms_done_r[k] <= zs_done_r[k];
        ms_idx_r[k] <= zs_idx_r[k];
      end
    end

    assign sqx = SW'(ms_pxx_r[k] >>> FB);
    assign sqy = SW'(ms_pyy_r[k] >>> FB);
    assign xy = SW'(ms_pxy_r[k] >>> (FB - 1));
    assign mag2 = sqx + sqy;
    assign esc_nxt = (k != 0) && !ms_done_r[k] && (ms_big_r[k] || (mag2 > SIXTEEN));
    assign done_nxt = ms_done_r[k] || esc_nxt;
    assign idx_nxt = esc_nxt ? IW'(RI) : ms_idx_r[k];

    if (k < MAX_ROUNDS) begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) zs_vld_r[k+1] <= 1'b0;
        else if (adv) zs_vld_r[k+1] <= ms_vld_r[k];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          zs_x_r[k+1] <= etfp_pkg::sat_z(sqx - sqy + SW'(ms_cx_r[k]));
          zs_y_r[k+1] <= etfp_pkg::sat_z(xy + SW'(ms_cy_r[k]));
          zs_cx_r[k+1] <= ms_cx_r[k];
          zs_cy_r[k+1] <= ms_cy_r[k];
          zs_done_r[k+1] <= done_nxt;
          zs_idx_r[k+1] <= idx_nxt;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (!rst_n) fin_vld_r <= 1'b0;
        else if (adv) fin_vld_r <= ms_vld_r[k];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          fin_esc_r <= done_nxt;
          fin_idx_r <= idx_nxt;
        end
      end
    end
  end

  // Output register with the color lookup.
  logic out_esc_r;
  logic [IW-1:0] out_idx_r;
  logic signed [CW-1:0] out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= fin_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_esc_r <= fin_esc_r;
      out_idx_r <= fin_esc_r ? fin_idx_r : '0;
      out_red_r <= fin_esc_r ? TAB_R[fin_idx_r] : '0;
      out_green_r <= fin_esc_r ? TAB_G[fin_idx_r] : '0;
      out_blue_r <= fin_esc_r ? TAB_B[fin_idx_r] : '0;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.escaped = out_esc_r;
  assign out_ch.round_index = out_idx_r;
  assign out_ch.red = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue = out_blue_r;

  `ETFP_ASSERT_IMP(a_no_escape_zero, out_vld_r && !out_esc_r, out_idx_r == '0 && out_red_r == '0 && out_green_r == '0 && out_blue_r == '0)
  `ETFP_ASSERT_NEXT(a_stall_holds, !adv, $stable(fin_vld_r) && $stable(zs_vld_r[0]))
  `ETFP_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, m0_vld_r)

endmodule
